// ===== rtl/svsl_pkg.sv =====
// Shared types and constants for the servo slew-limited PWM driver.
// Used by svsl_regs and servo_slew_pwm_driver_top; depends on nothing.
package svsl_pkg;

  // Control loop period in milliseconds; fixes the slew step per tick.
  localparam int unsigned PERIOD_MS = 10;

  // Step = speed * PERIOD_MS / 10, split into whole and fractional tenths.
  localparam int unsigned PeriodWhole = PERIOD_MS / 10;
  localparam int unsigned PeriodFrac  = PERIOD_MS % 10;

  // Reciprocal of ten for 16-bit operands: (x * 52429) >> 19 == x / 10.
  localparam logic [15:0] RecipTen = 16'd52429;
  localparam int unsigned RecipShift = 19;

  localparam int unsigned AngleW = 16;
  localparam int unsigned SlopeW = 20;
  localparam int unsigned SpeedW = 12;
  localparam int unsigned PulseW = 16;
  localparam int unsigned ProdW  = AngleW + SlopeW;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_SMOOTH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_PULSE_OFFSET = 3'd0,
    REG_PULSE_SLOPE  = 3'd1,
    REG_MAX_ANGLE    = 3'd2,
    REG_LIMIT_MIN    = 3'd3,
    REG_LIMIT_MAX    = 3'd4,
    REG_DONE_TOL     = 3'd5
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [15:0] RstPulseOffset = 16'd500;
  localparam logic [19:0] RstPulseSlope  = 20'd7282;
  localparam logic [15:0] RstMaxAngle    = 16'd18000;
  localparam logic [15:0] RstLimitMin    = 16'd0;
  localparam logic [15:0] RstLimitMax    = 16'd0;
  localparam logic [15:0] RstDoneTol     = 16'd0;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] pulse_offset;
    logic [19:0] pulse_slope;
    logic [15:0] max_angle;
    logic [15:0] angle_floor;
    logic [15:0] angle_ceil;
    logic [15:0] done_tolerance;
  } svsl_cfg_t;

endpackage

// ===== rtl/svsl_regs.sv =====
// APB-style configuration register file for the servo slew PWM driver.
// Depends on svsl_pkg for the register indexes, reset values and config struct.
module svsl_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output svsl_pkg::svsl_cfg_t    cfg_o
);
  import svsl_pkg::*;

  svsl_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  reg_idx_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  // Register writes; unused indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PULSE_OFFSET: cfg_d.pulse_offset    = pwdata[15:0];
        REG_PULSE_SLOPE:  cfg_d.pulse_slope     = pwdata[19:0];
        REG_MAX_ANGLE:    cfg_d.max_angle       = pwdata[15:0];
        REG_LIMIT_MIN:    cfg_d.angle_floor     = pwdata[15:0];
        REG_LIMIT_MAX:    cfg_d.angle_ceil      = pwdata[15:0];
        REG_DONE_TOL:     cfg_d.done_tolerance  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_offset    <= RstPulseOffset;
      cfg_q.pulse_slope     <= RstPulseSlope;
      cfg_q.max_angle       <= RstMaxAngle;
      cfg_q.angle_floor     <= RstLimitMin;
      cfg_q.angle_ceil      <= RstLimitMax;
      cfg_q.done_tolerance  <= RstDoneTol;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PULSE_OFFSET: prdata = {16'd0, cfg_q.pulse_offset};
      REG_PULSE_SLOPE:  prdata = {12'd0, cfg_q.pulse_slope};
      REG_MAX_ANGLE:    prdata = {16'd0, cfg_q.max_angle};
      REG_LIMIT_MIN:    prdata = {16'd0, cfg_q.angle_floor};
      REG_LIMIT_MAX:    prdata = {16'd0, cfg_q.angle_ceil};
      REG_DONE_TOL:     prdata = {16'd0, cfg_q.done_tolerance};
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/servo_slew_pwm_driver_top.sv =====
// Top level of the servo slew-limited PWM driver: stream datapath and state.
// Depends on svsl_pkg and instantiates svsl_regs.

// Each input beat is a tick, an angle command or a no-op; each produces exactly
// one output beat with the PWM compare value, the ramped angle and an at-target
// flag. The datapath is a four-stage pipeline (input capture with clamp and
// step computation, angle update, pulse multiply, offset add and saturate),
// so a beat is accepted every cycle while the output side is not stalled, and
// its result is registered through stages 0 to 3 before it is presented. The
// angle state is updated in a single stage, so back-to-back beats see each
// other's effect without bubbles. Stages advance independently, and empty
// stages fill even while the output beat waits. Configuration must be written
// through the APB port while idle; the block itself does not enforce this.
module servo_slew_pwm_driver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] angle_cmd, [27:16] speed, [31:28] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [15:0] pulse, [31:16] current_angle,
                                     // [32] at_target, [39:33] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svsl_pkg::*;

  svsl_cfg_t cfg;

  svsl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline flow control: a stage loads when it is empty or moves on.
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 0: capture, clamp the command and work out the new step.
  logic [AngleW-1:0] cmd_in, cmd_clamped;
  logic [SpeedW-1:0] spd_in;
  op_e               op_in;
  logic [15:0]       frac_prod;
  logic [31:0]       frac_scaled;
  logic [15:0]       step_in;

  assign cmd_in = s_axis_tdata[15:0];
  assign spd_in = s_axis_tdata[27:16];
  assign op_in  = op_e'(s_axis_tuser);

  always_comb begin
    if (cfg.angle_ceil != '0 && cmd_in > cfg.angle_ceil) begin
      cmd_clamped = cfg.angle_ceil;
    end else if (cmd_in < cfg.angle_floor) begin
      cmd_clamped = cfg.angle_floor;
    end else begin
      cmd_clamped = cmd_in;
    end
  end

  // Whole periods of ten add speed directly; the remainder is divided by ten.
  assign frac_prod   = 16'({4'd0, spd_in} * 16'(PeriodFrac));
  assign frac_scaled = frac_prod * RecipTen;
  assign step_in     = 16'({4'd0, spd_in} * 16'(PeriodWhole))
                     + 16'(frac_scaled >> RecipShift);

  op_e               op0_q;
  logic              jump0_q;
  logic [AngleW-1:0] cmd0_q;
  logic [15:0]       step0_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      op0_q   <= op_in;
      jump0_q <= (op_in == OP_SET) || (op_in == OP_SMOOTH && spd_in == '0);
      cmd0_q  <= cmd_clamped;
      step0_q <= step_in;
    end
  end

  // Stage 1: update the ramp state once per item.
  logic [AngleW-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [15:0]       step_q, step_d;
  logic [AngleW-1:0] ramp_err;
  logic              take1;

  assign take1    = rdy1 && v0_q;
  assign ramp_err = (tgt_q > cur_q) ? tgt_q - cur_q : cur_q - tgt_q;

  always_comb begin
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    step_d = step_q;
    if (jump0_q) begin
      cur_d  = cmd0_q;
      tgt_d  = cmd0_q;
      step_d = '0;
    end else begin
      case (op0_q)
        OP_SMOOTH: begin
          tgt_d  = cmd0_q;
          step_d = step0_q;
        end
        OP_TICK: begin
          if (ramp_err <= step_q) begin
            cur_d = tgt_q;
          end else if (tgt_q > cur_q) begin
            cur_d = cur_q + step_q;
          end else begin
            cur_d = cur_q - step_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      tgt_q  <= '0;
      step_q <= '0;
    end else if (take1) begin
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      step_q <= step_d;
    end
  end

  logic [AngleW-1:0] cur1_q, tgt1_q;

  always_ff @(posedge clk_i) begin
    if (take1) begin
      cur1_q <= cur_d;
      tgt1_q <= tgt_d;
    end
  end

  // Stage 2: cap the angle, multiply by the slope, check the tolerance.
  logic [AngleW-1:0] capped, err1;
  logic [ProdW-1:0]  prod2_q;
  logic [AngleW-1:0] cur2_q;
  logic              at2_q;

  assign capped = (cur1_q > cfg.max_angle) ? cfg.max_angle : cur1_q;
  assign err1   = (tgt1_q > cur1_q) ? tgt1_q - cur1_q : cur1_q - tgt1_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prod2_q <= ProdW'(capped) * ProdW'(cfg.pulse_slope);
      cur2_q  <= cur1_q;
      at2_q   <= (err1 <= cfg.done_tolerance);
    end
  end

  // Stage 3: add the offset and saturate into the output register.
  logic [SlopeW:0]   pulse_sum;
  logic [PulseW-1:0] pulse_sat;
  logic [PulseW-1:0] pulse3_q;
  logic [AngleW-1:0] cur3_q;
  logic              at3_q;

  assign pulse_sum = (SlopeW+1)'(cfg.pulse_offset) + (SlopeW+1)'(prod2_q[ProdW-1:16]);
  assign pulse_sat = (pulse_sum[SlopeW:PulseW] != '0) ? '1 : pulse_sum[PulseW-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pulse3_q <= pulse_sat;
      cur3_q   <= cur2_q;
      at3_q    <= at2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {7'd0, at3_q, cur3_q, pulse3_q};

`ifndef ASSERT_OFF
  // A jump command leaves no step behind.
  a_jump_clears_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take1 && jump0_q) |=> (step_q == '0))
    else $error("step not cleared after jump command");

  // A tick within one step of the target lands exactly on it.
  a_tick_snaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take1 && !jump0_q && op0_q == OP_TICK && ramp_err <= step_q) |=> (cur_q == tgt_q))
    else $error("tick within one step did not snap to target");

  // The pulse never falls below the configured offset.
  a_pulse_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] >= cfg.pulse_offset))
    else $error("pulse below offset");
`endif

endmodule

// ===== bench/servo_slew_pwm_driver_top_tb.sv =====
// Self-checking testbench for servo_slew_pwm_driver_top: stream beats in,
// predicted results compared field by field, configuration over APB.
// Depends on svsl_pkg and the RTL of servo_slew_pwm_driver_top only.
`timescale 1ns / 100ps

module servo_slew_pwm_driver_top_tb;
  import svsl_pkg::*;

  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned MaxReports    = 40;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned ItemsPerPhase = 90;

  // One result beat as the testbench sees it.
  typedef struct packed {
    logic [15:0] pulse;
    logic [15:0] angle;
    logic        done;
  } servo_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] angle_cmd, [27:16] speed, [31:28] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [15:0] pulse, [31:16] current_angle,
                                    // [32] at_target, [39:33] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: configuration and ramp state.
  svsl_cfg_t   cfg;
  logic [15:0] cur_angle;
  logic [15:0] tgt_angle;
  logic [15:0] slew_step;

  servo_result_t result_q[$];
  int unsigned   err_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_left = 0;
  bit            in_idle_on = 1'b1;
  bit            out_idle_on = 1'b1;
  bit            tvalid_up = 1'b0;

  servo_slew_pwm_driver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] angle_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // An upper limit of zero means no upper limit; the lower limit applies otherwise.
  function automatic logic [15:0] limit_angle(logic [15:0] a);
    if (cfg.angle_ceil != 16'd0 && a > cfg.angle_ceil) return cfg.angle_ceil;
    if (a < cfg.angle_floor) return cfg.angle_floor;
    return a;
  endfunction

  // Compare value: offset plus Q16 slope times the capped angle, saturated.
  function automatic logic [15:0] pulse_for(logic [15:0] a);
    logic [15:0] capped;
    logic [35:0] prod;
    logic [36:0] total;
    capped = (a > cfg.max_angle) ? cfg.max_angle : a;
    prod = capped * cfg.pulse_slope;
    total = {21'd0, cfg.pulse_offset} + {17'd0, prod[35:16]};
    return (total > 37'd65535) ? 16'hFFFF : total[15:0];
  endfunction

  // Applies one accepted item to the shadow state and returns its result.
  function automatic servo_result_t advance_servo(op_e op, logic [15:0] cmd,
                                                  logic [11:0] spd);
    servo_result_t res;
    int unsigned   prod;
    if (op == OP_SET || (op == OP_SMOOTH && spd == 12'd0)) begin
      cur_angle = limit_angle(cmd);
      tgt_angle = cur_angle;
      slew_step = 16'd0;
    end else if (op == OP_SMOOTH) begin
      tgt_angle = limit_angle(cmd);
      prod = spd * PERIOD_MS / 10;
      slew_step = 16'(prod);
    end else if (op == OP_TICK) begin
      // Snap to the target when within one step, else move one step toward it.
      if (angle_gap(tgt_angle, cur_angle) <= slew_step) cur_angle = tgt_angle;
      else if (tgt_angle > cur_angle) cur_angle = cur_angle + slew_step;
      else cur_angle = cur_angle - slew_step;
    end
    res.pulse = pulse_for(cur_angle);
    res.angle = cur_angle;
    res.done = (angle_gap(tgt_angle, cur_angle) <= cfg.done_tolerance);
    return res;
  endfunction

  // Sends one input beat, records its expected result, then sometimes idles a while.
  task automatic send_item(op_e op, logic [15:0] cmd, logic [11:0] spd);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'd0, spd, cmd};
    tvalid_up = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(advance_servo(op, cmd, spd));
    gap = in_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      // Junk on the data lines while tvalid is low must be ignored.
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;
      s_axis_tuser <= 2'($urandom);
      tvalid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every result is in and the pipeline has settled.
  task automatic wait_drained();
    if (tvalid_up) s_axis_tvalid <= 1'b0;
    tvalid_up = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one register, then reads it back and checks the value.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] seen;
    mask = (idx == REG_PULSE_SLOPE) ? 32'h000F_FFFF : 32'h0000_FFFF;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    seen = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PULSE_OFFSET: cfg.pulse_offset = value[15:0];
      REG_PULSE_SLOPE:  cfg.pulse_slope = value[19:0];
      REG_MAX_ANGLE:    cfg.max_angle = value[15:0];
      REG_LIMIT_MIN:    cfg.angle_floor = value[15:0];
      REG_LIMIT_MAX:    cfg.angle_ceil = value[15:0];
      REG_DONE_TOL:     cfg.done_tolerance = value[15:0];
      default: ;
    endcase
    if ((seen & mask) !== (value & mask)) begin
      err_count++;
      if (err_count <= MaxReports)
        $display("%0t: readback of %s expected %0d actual %0d", $time, idx.name(),
                 value & mask, seen & mask);
    end
  endtask

  // Reset configuration: zero angle, pulse cap at the maximum angle, coarse and
  // fine ramps with snapping, speed zero as a jump, and the unused opcode.
  task automatic test_default_mapping();
    send_item(OP_TICK, 16'd0, 12'd0);
    send_item(OP_SET, 16'd9000, 12'd0);
    send_item(OP_SET, 16'd36000, 12'd0);
    send_item(OP_SET, 16'hFFFF, 12'hFFF);
    send_item(OP_SET, 16'd0, 12'd0);
    send_item(OP_NONE, 16'd1234, 12'd77);
    send_item(OP_SMOOTH, 16'd12345, 12'd0);
    send_item(OP_SMOOTH, 16'd0, 12'd4095);
    repeat (4) send_item(OP_TICK, 16'hFFFF, 12'hFFF);
    send_item(OP_SMOOTH, 16'd3, 12'd1);
    repeat (3) send_item(OP_TICK, 16'd0, 12'd0);
  endtask

  // Clamping to both limits, done tolerance, and the pulse extremes.
  task automatic test_limits_and_saturation();
    wait_drained();
    write_reg(REG_PULSE_OFFSET, 32'd65535);
    write_reg(REG_PULSE_SLOPE, 32'h000F_FFFF);
    write_reg(REG_MAX_ANGLE, 32'd36000);
    write_reg(REG_LIMIT_MIN, 32'd1000);
    write_reg(REG_LIMIT_MAX, 32'd30000);
    write_reg(REG_DONE_TOL, 32'd100);
    send_item(OP_SET, 16'd0, 12'd0);
    send_item(OP_SET, 16'd36000, 12'd0);
    send_item(OP_SMOOTH, 16'd200, 12'd50);
    repeat (2) send_item(OP_TICK, 16'd0, 12'd0);
    wait_drained();
    write_reg(REG_PULSE_OFFSET, 32'd0);
    write_reg(REG_PULSE_SLOPE, 32'd0);
    write_reg(REG_MAX_ANGLE, 32'd1);
    write_reg(REG_LIMIT_MIN, 32'd36000);
    write_reg(REG_LIMIT_MAX, 32'd36000);
    write_reg(REG_DONE_TOL, 32'd0);
    send_item(OP_SET, 16'd5, 12'd0);
    send_item(OP_TICK, 16'd0, 12'd0);
  endtask

  // Random phases: each writes a fresh configuration, then mostly smooth moves
  // followed by enough ticks to finish (or interrupt) the ramp, plus noise.
  task automatic test_random_ramps();
    int unsigned r;
    int unsigned sent;
    int unsigned n_ticks;
    logic [15:0] angle;
    logic [11:0] spd;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      in_idle_on = !((ph % 3) == 1 || ph == 3);
      out_idle_on = !((ph % 3) == 2 || ph == 3);
      write_reg(REG_PULSE_OFFSET, $urandom_range(0, 65535));
      write_reg(REG_PULSE_SLOPE, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16000)
                                                               : $urandom_range(0, 20'hFFFFF));
      write_reg(REG_MAX_ANGLE, $urandom_range(1, 36000));
      write_reg(REG_LIMIT_MIN, ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 9000));
      write_reg(REG_LIMIT_MAX, ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(9000, 36000));
      r = $urandom_range(0, 9);
      write_reg(REG_DONE_TOL, (r < 4) ? 0 : (r < 8) ? $urandom_range(0, 300)
                                                    : $urandom_range(0, 36000));
      sent = 0;
      while (sent < ItemsPerPhase) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          angle = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 36000));
          r = $urandom_range(0, 99);
          if (r < 10) spd = 12'd0;
          else if (r < 25) spd = 12'($urandom_range(1, 30));
          else if (r < 85) spd = 12'($urandom_range(31, 600));
          else spd = 12'($urandom_range(601, 4095));
          send_item(OP_SMOOTH, angle, spd);
          // Usually run the ramp out to the snap; sometimes cut it short.
          if (slew_step == 16'd0) n_ticks = $urandom_range(1, 4);
          else n_ticks = angle_gap(tgt_angle, cur_angle) / slew_step + $urandom_range(0, 2);
          if (n_ticks > 30) n_ticks = 30;
          if ($urandom_range(0, 3) == 0) n_ticks = $urandom_range(1, 5);
          repeat (n_ticks) send_item(OP_TICK, 16'($urandom), 12'($urandom));
          sent += 1 + n_ticks;
        end else if (r < 82) begin
          send_item(OP_SET, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 36000)),
                    12'($urandom));
          sent++;
        end else if (r < 90) begin
          send_item(OP_TICK, 16'($urandom), 12'($urandom));
          sent++;
        end else if (r < 95) begin
          send_item(OP_NONE, 16'($urandom), 12'($urandom));
        end else begin
          send_item(OP_SMOOTH, 16'($urandom), 12'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Output side: random stalls while enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rst_ni && out_idle_on && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    servo_result_t seen;
    servo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.pulse = m_axis_tdata[15:0];
      seen.angle = m_axis_tdata[31:16];
      seen.done = m_axis_tdata[32];
      if (result_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: unexpected beat expected none actual pulse %0d angle %0d done %0b",
                   $time, seen.pulse, seen.angle, seen.done);
      end else begin
        want = result_q.pop_front();
        if (seen !== want) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("%0t: expected pulse %0d angle %0d done %0b actual pulse %0d angle %0d done %0b",
                     $time, want.pulse, want.angle, want.done,
                     seen.pulse, seen.angle, seen.done);
        end
      end
    end
  end

  // Watchdog: too long without any beat or register access ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                 StallLimit, result_q.size());
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    cfg.pulse_offset = RstPulseOffset;
    cfg.pulse_slope = RstPulseSlope;
    cfg.max_angle = RstMaxAngle;
    cfg.angle_floor = RstLimitMin;
    cfg.angle_ceil = RstLimitMax;
    cfg.done_tolerance = RstDoneTol;
    cur_angle = '0;
    tgt_angle = '0;
    slew_step = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_mapping();
    test_limits_and_saturation();
    test_random_ramps();
    wait_drained();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
